// ===== hw/rtl/trq_pkg.sv =====
// trq_pkg: shared types, codes and widths for the task ready queue
// used by trq_if, trq_cell and task_ready_queue
package trq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FUNC_W          = 3;
	localparam int ID_W            = 8;
	localparam int ARR_W           = 32;
	localparam int STATUS_W        = 2;
	localparam int COUNT_W         = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_SORTED_INS = 3'd0,
		FN_TAIL_INS   = 3'd1,
		FN_POP        = 3'd2,
		FN_REMOVE     = 3'd3,
		FN_FIND       = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// one queue slot
	typedef struct packed {
		logic             vld;
		logic [ID_W-1:0]  id;
		logic [ARR_W-1:0] arr;
	} entry_t;

	// per-cell update command
	typedef struct packed {
		logic take_new;
		logic take_left;
		logic take_right;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/trq_if.sv =====
// trq_if: request and response channel interfaces of the task ready queue
// depends on trq_pkg for field widths
interface trq_in_if;
	logic                        valid;
	logic                        ready;
	logic [trq_pkg::FUNC_W-1:0]  func;
	logic [trq_pkg::ID_W-1:0]    task_id;
	logic [trq_pkg::ARR_W-1:0]   task_arrival;

	modport source (output valid, func, task_id, task_arrival, input ready);
	modport sink (input valid, func, task_id, task_arrival, output ready);
endinterface

interface trq_out_if;
	logic                         valid;
	logic                         ready;
	logic [trq_pkg::STATUS_W-1:0] status;
	logic [trq_pkg::ID_W-1:0]     out_id;
	logic [trq_pkg::ARR_W-1:0]    out_arrival;
	logic                         is_empty;
	logic [trq_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, status, out_id, out_arrival, is_empty, entry_count,
		input ready);
	modport sink (input valid, status, out_id, out_arrival, is_empty, entry_count,
		output ready);
endinterface

// ===== hw/rtl/task_ready_queue.sv =====
// task_ready_queue: top level, a row of trq_cell slots with a request
// register and a response register; depends on trq_pkg, trq_if, trq_cell, trq_prefix
//
//   channel | direction | carries
//   req     | in        | func, task_id, task_arrival
//   rsp     | out       | status, out_id, out_arrival, is_empty, entry_count
//
// each request is first held in the request register; then the cells compare,
// shift and load while the response register is written
// the row compares in parallel, so the time does not grow with QUEUE_DEPTH
// a new request is taken as soon as the request register has moved on,
// also while a response waits; a stalled response holds the request register
// reset empties every cell and the count; slot payloads are not cleared
module task_ready_queue #(
	parameter int QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	trq_in_if.sink        req,
	trq_out_if.source     rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// request register
	logic                       vld_s1;
	logic [trq_pkg::FUNC_W-1:0] func_s1;
	logic [trq_pkg::ID_W-1:0]   id_s1;
	logic [trq_pkg::ARR_W-1:0]  arr_s1;

	logic [CW-1:0] occ_q;

	// response register
	logic                         rsp_vld_q;
	logic [trq_pkg::STATUS_W-1:0] status_q;
	logic [trq_pkg::ID_W-1:0]     out_id_q;
	logic [trq_pkg::ARR_W-1:0]    out_arr_q;
	logic                         empty_q;
	logic [trq_pkg::COUNT_W-1:0]  count_q;

	trq_pkg::entry_t    ent [QUEUE_DEPTH];
	trq_pkg::cell_cmd_t cmd [QUEUE_DEPTH];
	trq_pkg::entry_t    new_entry;

	logic [QUEUE_DEPTH-1:0] vld_v, later_v, idm_v;
	logic [QUEUE_DEPTH-1:0] ins_hit, ins_incl, ins_first;
	logic [QUEUE_DEPTH-1:0] rm_hit, rm_incl, rm_first;

	logic                         advance;
	logic                         is_ins, is_extract, is_shrink, full, found;
	logic                         do_ins, do_rm;
	trq_pkg::status_t             status_n;
	logic [trq_pkg::ID_W-1:0]     sel_id;
	logic [trq_pkg::ARR_W-1:0]    sel_arr;
	logic [CW-1:0]                occ_n;

	assign req.ready = !vld_s1;
	assign advance   = vld_s1 && (!rsp_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			id_s1   <= req.task_id;
			arr_s1  <= req.task_arrival;
		end
	end

	// cell row
	assign new_entry = '{vld: 1'b1, id: id_s1, arr: arr_s1};

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		trq_pkg::entry_t left_e, right_e;
		if (g == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_mid
			assign left_e = ent[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = ent[g+1];
		end

		assign cmd[g].take_new   = do_ins && ins_first[g];
		assign cmd[g].take_left  = do_ins && ins_incl[g] && !ins_first[g];
		assign cmd[g].take_right = do_rm && rm_incl[g];

		trq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd[g]),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.key_id      (id_s1),
			.key_arr     (arr_s1),
			.entry       (ent[g]),
			.later       (later_v[g]),
			.id_hit      (idm_v[g])
		);

		assign vld_v[g] = ent[g].vld;
	end

	// decode
	always_comb begin
		is_ins     = 1'b0;
		is_extract = 1'b0;
		is_shrink  = 1'b0;
		ins_hit    = ~vld_v;
		rm_hit     = idm_v;
		unique case (func_s1)
			trq_pkg::FN_SORTED_INS: begin
				is_ins  = 1'b1;
				ins_hit = later_v | ~vld_v;
			end
			trq_pkg::FN_TAIL_INS: begin
				is_ins = 1'b1;
			end
			trq_pkg::FN_POP: begin
				is_extract = 1'b1;
				is_shrink  = 1'b1;
				rm_hit     = {{(QUEUE_DEPTH-1){1'b0}}, vld_v[0]};
			end
			trq_pkg::FN_REMOVE: begin
				is_extract = 1'b1;
				is_shrink  = 1'b1;
			end
			trq_pkg::FN_FIND: begin
				is_extract = 1'b1;
			end
			default: begin
			end
		endcase
	end

	trq_prefix #(.N(QUEUE_DEPTH)) u_ins_prefix (
		.hit   (ins_hit),
		.incl  (ins_incl),
		.first (ins_first)
	);

	trq_prefix #(.N(QUEUE_DEPTH)) u_rm_prefix (
		.hit   (rm_hit),
		.incl  (rm_incl),
		.first (rm_first)
	);

	assign full   = vld_v[QUEUE_DEPTH-1];
	assign found  = |rm_hit;
	assign do_ins = advance && is_ins && !full;
	assign do_rm  = advance && is_shrink && found;

	always_comb begin
		sel_id  = '0;
		sel_arr = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_id  = sel_id | ({trq_pkg::ID_W{rm_first[i]}} & ent[i].id);
			sel_arr = sel_arr | ({trq_pkg::ARR_W{rm_first[i]}} & ent[i].arr);
		end
	end

	always_comb begin
		status_n = trq_pkg::ST_OK;
		if (is_ins && full) begin
			status_n = trq_pkg::ST_FULL;
		end else if (func_s1 == trq_pkg::FN_POP && !found) begin
			status_n = trq_pkg::ST_EMPTY;
		end else if (is_extract && !found) begin
			status_n = trq_pkg::ST_NOTFOUND;
		end
	end

	always_comb begin
		occ_n = occ_q;
		if (do_ins) begin
			occ_n = occ_q + CW'(1);
		end else if (do_rm) begin
			occ_n = occ_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			occ_q <= occ_n;
			if (advance) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_n;
			out_id_q  <= (is_extract && found) ? sel_id : '0;
			out_arr_q <= (is_extract && found) ? sel_arr : '0;
			empty_q   <= (occ_n == '0);
			count_q   <= trq_pkg::COUNT_W'(occ_n);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = status_q;
	assign rsp.out_id      = out_id_q;
	assign rsp.out_arrival = out_arr_q;
	assign rsp.is_empty    = empty_q;
	assign rsp.entry_count = count_q;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(QUEUE_DEPTH))
		else $error("occupancy above depth");

	a_occ_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_v) == int'(occ_q))
		else $error("cell valid bits disagree with occupancy");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status_n == trq_pkg::ST_FULL |-> occ_q == CW'(QUEUE_DEPTH))
		else $error("full status with room left");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(occ_q))
		else $error("stalled request changed the queue");

endmodule

// ===== hw/rtl/trq_cell.sv =====
// trq_cell: one queue slot; compares against the request key and
// loads a new entry or a neighbor's entry; depends on trq_pkg
module trq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  trq_pkg::cell_cmd_t         cmd,
	input  trq_pkg::entry_t            new_entry,
	input  trq_pkg::entry_t            left_entry,
	input  trq_pkg::entry_t            right_entry,
	input  logic [trq_pkg::ID_W-1:0]   key_id,
	input  logic [trq_pkg::ARR_W-1:0]  key_arr,
	output trq_pkg::entry_t            entry,
	output logic                       later,
	output logic                       id_hit
);

	logic                      vld_q;
	logic [trq_pkg::ID_W-1:0]  id_q;
	logic [trq_pkg::ARR_W-1:0] arr_q;
	trq_pkg::entry_t           nxt;

	always_comb begin
		nxt = entry;
		if (cmd.take_new) begin
			nxt = new_entry;
		end else if (cmd.take_left) begin
			nxt = left_entry;
		end else if (cmd.take_right) begin
			nxt = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= nxt.id;
		arr_q <= nxt.arr;
	end

	assign entry  = '{vld: vld_q, id: id_q, arr: arr_q};
	assign later  = vld_q && (arr_q > key_arr);
	assign id_hit = vld_q && (id_q == key_id);

endmodule

// ===== hw/rtl/trq_prefix.sv =====
// trq_prefix: inclusive prefix-or and first-set marker over the cell row
// log-depth doubling steps; no package dependency
module trq_prefix #(
	parameter int N = 16
) (
	input  logic [N-1:0] hit,
	output logic [N-1:0] incl,
	output logic [N-1:0] first
);

	localparam int STEPS = (N > 1) ? $clog2(N) : 1;

	always_comb begin
		incl = hit;
		for (int k = 0; k < STEPS; k++) begin
			incl = incl | (incl << (1 << k));
		end
		first = incl & ~(incl << 1);
	end

endmodule
